// File: rtl/core/bia_pkg.sv
// Shared types, codes and default sizes for the bitmap id allocator.
`timescale 1ns / 1ps

package bia_pkg;

	// Default table shape; ID_WORDS * WORD_BITS must not exceed 256 (ids are 8 bits).
	localparam int ID_WORDS_DEF    = 4;
	localparam int WORD_BITS_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int VALUE_BITS = 32;
	localparam int ID_BITS    = 8;
	localparam int CFG_BITS   = 3;

	localparam logic [1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_FREE   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_LOOKUP,
		OP_FREE,
		OP_BAD
	} bia_op_t;

	typedef struct packed {
		logic [1:0]            func;
		logic [ID_BITS-1:0]    id_in;
		logic [VALUE_BITS-1:0] value_in;
	} bia_req_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    id_out;
		logic [VALUE_BITS-1:0] value_out;
		logic [1:0]            status;
	} bia_rsp_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		bia_op_t               op;
		logic                  in_range;
		logic [ID_BITS-1:0]    id;
		logic [VALUE_BITS-1:0] value;
	} bia_cmd_t;

endpackage

// File: rtl/core/bia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bia_queue.sv
// Small FIFO of classified requests between the front end and the back end.
`timescale 1ns / 1ps

module bia_queue #(
	parameter int DEPTH = bia_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  bia_pkg::bia_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bia_pkg::bia_cmd_t pop_data
);

	import bia_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bia_cmd_t        entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/bia_front.sv
// Front end: word-count register, request decode and id range check.
`timescale 1ns / 1ps

module bia_front #(
	parameter int ID_WORDS  = bia_pkg::ID_WORDS_DEF,
	parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  bia_pkg::bia_req_t                  req,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bia_pkg::CFG_BITS-1:0]       cfg_data,
	output logic                               push_valid,
	input  logic                               push_ready,
	output bia_pkg::bia_cmd_t                  push_data,
	output logic [$clog2(ID_WORDS + 1)-1:0]    words
);

	import bia_pkg::*;

	localparam int NW = $clog2(ID_WORDS + 1);

	logic [CFG_BITS-1:0] words_in_use_q;
	bia_op_t             op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= CFG_BITS'(ID_WORDS);
		end else if (cfg_valid) begin
			words_in_use_q <= cfg_data;
		end
	end

	// Clamp the programmed count to 1..ID_WORDS.
	always_comb begin
		if (words_in_use_q == '0) begin
			words = NW'(1);
		end else if (int'(words_in_use_q) > ID_WORDS) begin
			words = NW'(ID_WORDS);
		end else begin
			words = NW'(words_in_use_q);
		end
	end

	always_comb begin
		unique case (req.func)
			FUNC_ALLOC:  op = OP_ALLOC;
			FUNC_LOOKUP: op = OP_LOOKUP;
			FUNC_FREE:   op = OP_FREE;
			default:     op = OP_BAD;
		endcase
	end

	assign push_valid         = req_valid;
	assign req_ready          = push_ready;
	assign push_data.op       = op;
	assign push_data.in_range = (int'(req.id_in) < int'(words) * WORD_BITS);
	assign push_data.id       = req.id_in;
	assign push_data.value    = req.value_in;

endmodule

// File: rtl/core/bia_back.sv
// Back end: used-bit bitmap, next-fit word scan, value store and response register.
`timescale 1ns / 1ps

module bia_back #(
	parameter int ID_WORDS  = bia_pkg::ID_WORDS_DEF,
	parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(ID_WORDS + 1)-1:0] words,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  bia_pkg::bia_cmd_t               cmd,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output bia_pkg::bia_rsp_t               rsp
);

	import bia_pkg::*;

	localparam int TOTAL = ID_WORDS * WORD_BITS;
	localparam int NW    = $clog2(ID_WORDS + 1);
	localparam int WW    = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int AW    = $clog2(TOTAL);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_READ = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [TOTAL-1:0]      bitmap_q;
	logic [NW-1:0]         next_w_q;
	logic [BW-1:0]         next_b_q;
	logic [WW-1:0]         w_q;
	logic [NW-1:0]         k_q;
	logic [BW-1:0]         sb_q;
	logic [ID_BITS-1:0]    id_q;
	logic [VALUE_BITS-1:0] value_q;
	bia_rsp_t              res_q;
	bia_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  hi_mask;
	logic [WORD_BITS-1:0]  avail;
	logic [WORD_BITS-1:0]  lsb;
	logic [BW-1:0]         hit_bit;
	logic                  found;
	logic                  scan_last;
	logic [AW-1:0]         cand;
	logic [AW-1:0]         head_addr;
	logic                  head_used;
	logic                  start_wrap;
	logic                  take;
	logic                  ram_re;
	logic                  ram_we;
	logic                  emit_go;
	logic [VALUE_BITS-1:0] ram_rdata;

	// One bitmap word per scan cycle; first visit skips bits below the start,
	// the final revisit of the start word covers only those bits.
	always_comb begin
		word      = bitmap_q[int'(w_q) * WORD_BITS +: WORD_BITS];
		hi_mask   = {WORD_BITS{1'b1}} << sb_q;
		scan_last = (k_q == words);
		if (k_q == '0) begin
			avail = ~word & hi_mask;
		end else if (scan_last) begin
			avail = ~word & ~hi_mask;
		end else begin
			avail = ~word;
		end
		lsb     = avail & (~avail + WORD_BITS'(1));
		hit_bit = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (lsb[b]) begin
				hit_bit = hit_bit | BW'(b);
			end
		end
		found = |avail;
		cand  = AW'(int'(w_q) * WORD_BITS + int'(hit_bit));
	end

	assign head_addr  = AW'(cmd.id);
	assign head_used  = bitmap_q[head_addr];
	assign start_wrap = (next_w_q >= words);
	assign cmd_ready  = (state_q == S_IDLE);
	assign take       = cmd_valid && cmd_ready;
	assign ram_re     = take && (cmd.op == OP_LOOKUP) && cmd.in_range && head_used;
	assign ram_we     = (state_q == S_SCAN) && found;
	assign emit_go    = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	bia_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TOTAL)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cand),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (head_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bitmap_q    <= '0;
			next_w_q    <= '0;
			next_b_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_ALLOC:  state_q <= S_SCAN;
							OP_LOOKUP: state_q <= ram_re ? S_READ : S_EMIT;
							OP_FREE: begin
								if (cmd.in_range) begin
									bitmap_q[head_addr] <= 1'b0;
								end
								state_q <= S_EMIT;
							end
							OP_BAD:    state_q <= S_EMIT;
						endcase
					end
				end
				S_SCAN: begin
					if (found) begin
						bitmap_q[cand] <= 1'b1;
						if (hit_bit == BW'(WORD_BITS - 1)) begin
							next_w_q <= NW'(w_q) + NW'(1);
							next_b_q <= '0;
						end else begin
							next_w_q <= NW'(w_q);
							next_b_q <= hit_bit + BW'(1);
						end
						state_q <= S_EMIT;
					end else if (scan_last) begin
						state_q <= S_EMIT;
					end
				end
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_q    <= cmd.id;
			value_q <= cmd.value;
			k_q     <= '0;
			w_q     <= start_wrap ? '0 : WW'(next_w_q);
			sb_q    <= start_wrap ? '0 : next_b_q;
			// Default response; allocate and lookup hits overwrite it later.
			res_q.id_out    <= cmd.id;
			res_q.value_out <= '0;
			res_q.status    <= (cmd.op == OP_FREE && cmd.in_range) ? STAT_OK : STAT_NOT_FOUND;
		end
		if (state_q == S_SCAN) begin
			if (found) begin
				res_q.id_out    <= ID_BITS'(cand);
				res_q.value_out <= '0;
				res_q.status    <= STAT_OK;
			end else if (scan_last) begin
				res_q.id_out    <= '0;
				res_q.value_out <= '0;
				res_q.status    <= STAT_FULL;
			end
			k_q <= k_q + NW'(1);
			w_q <= (NW'(w_q) == words - NW'(1)) ? '0 : w_q + WW'(1);
		end
		if (state_q == S_READ) begin
			res_q.id_out    <= id_q;
			res_q.value_out <= ram_rdata;
			res_q.status    <= STAT_OK;
		end
		if (emit_go) begin
			rsp_q <= res_q;
		end
	end

endmodule

// File: rtl/core/bitmap_id_allocator_table.sv
// Bitmap id allocator table. Requests (allocate, lookup, free) are decoded by a front end and
// queued in a QUEUE_DEPTH-entry FIFO, so new requests are taken while the back end works and
// while a finished response waits in the output register. A taken request is registered
// in the FIFO before the back end can pop it. The back end handles one request at a time:
// free, a lookup miss and an undefined code go straight to the emit state, a lookup hit
// passes through a read state for the value store's registered read, and allocate runs the
// next-fit search, which reads one bitmap word per cycle, starting past the last allocated
// id and wrapping back to the start word. The used bitmap is cleared by reset; the value
// store has no reset and is only read for used ids. The user must write words_in_use through
// the cfg channel only while no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps

module bitmap_id_allocator_table #(
	parameter int ID_WORDS    = bia_pkg::ID_WORDS_DEF,
	parameter int WORD_BITS   = bia_pkg::WORD_BITS_DEF,
	parameter int QUEUE_DEPTH = bia_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  bia_pkg::bia_req_t            req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output bia_pkg::bia_rsp_t            rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bia_pkg::CFG_BITS-1:0] cfg_data
);

	import bia_pkg::*;

	localparam int NW = $clog2(ID_WORDS + 1);

	logic          push_valid;
	logic          push_ready;
	bia_cmd_t      push_data;
	logic          cmd_valid;
	logic          cmd_ready;
	bia_cmd_t      cmd;
	logic [NW-1:0] words;

	bia_front #(
		.ID_WORDS  (ID_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.words      (words)
	);

	bia_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_data   (cmd)
	);

	bia_back #(
		.ID_WORDS  (ID_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: rtl/core/bia_checker.sv
// Port-level assertions for the allocator table, bound to the top level.
`timescale 1ns / 1ps

module bia_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input bia_pkg::bia_req_t            req,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input bia_pkg::bia_rsp_t            rsp,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [bia_pkg::CFG_BITS-1:0] cfg_data
);

	import bia_pkg::*;

	// Requests taken but not yet answered.
	logic [8:0] pending_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_take && !rsp_take) begin
			pending_q <= pending_q + 9'd1;
		end else if (rsp_take && !req_take) begin
			pending_q <= pending_q - 9'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 9'd0)
		else $error("response without an outstanding request");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.id_out == '0 && rsp.value_out == '0)
		else $error("full response carries a nonzero id or value");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_OK |-> rsp.value_out == '0)
		else $error("failed request returned a value");

	// Config is checked only for data held stable while a write is not ready.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready || $stable(cfg_data))
		else $error("config write stalled with changing data");

endmodule

bind bitmap_id_allocator_table bia_checker u_bia_checker (.*);

// File: bench/tb_bitmap_id_allocator_table.sv
// Testbench for bitmap_id_allocator_table: directed and random requests checked against a local table predictor.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator_table;
	import bia_pkg::*;

	localparam int TOTAL_IDS   = ID_WORDS_DEF * WORD_BITS_DEF;
	localparam int STALL_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	bia_req_t            req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	bia_rsp_t            rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = '0;

	// table model
	logic [TOTAL_IDS-1:0]  used_ids;
	logic [VALUE_BITS-1:0] id_values [TOTAL_IDS];
	logic [8:0]            search_from;
	logic [CFG_BITS-1:0]   words_cfg;

	bia_req_t req_backlog[$];
	bia_rsp_t rsp_due[$];
	int       err_cnt = 0;
	int       send_gap = 0;
	int       hold_cnt = 0;
	int       quiet_cycles = 0;
	bit       no_idle = 1'b0;

	bitmap_id_allocator_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// word count is clamped to 1..ID_WORDS
	function automatic int id_span(logic [CFG_BITS-1:0] words);
		int w;
		w = words;
		if (w < 1)
			w = 1;
		if (w > ID_WORDS_DEF)
			w = ID_WORDS_DEF;
		return w * WORD_BITS_DEF;
	endfunction

	function automatic bia_rsp_t table_predict(bia_req_t r);
		bia_rsp_t res;
		int span;
		int start;
		int cand;
		span = id_span(words_cfg);
		res = '{id_out: r.id_in, value_out: '0, status: STAT_NOT_FOUND};
		case (bia_op_t'(r.func))
			OP_ALLOC: begin
				res = '{id_out: '0, value_out: '0, status: STAT_FULL};
				start = (int'(search_from) >= span) ? 0 : int'(search_from);
				for (int k = 0; k < span; k++) begin
					cand = (start + k) % span;
					if (!used_ids[cand]) begin
						used_ids[cand] = 1'b1;
						id_values[cand] = r.value_in;
						search_from = 9'(cand + 1);
						res = '{id_out: ID_BITS'(cand), value_out: '0, status: STAT_OK};
						break;
					end
				end
			end
			OP_LOOKUP: begin
				if (int'(r.id_in) < span && used_ids[r.id_in])
					res = '{id_out: r.id_in, value_out: id_values[r.id_in], status: STAT_OK};
			end
			OP_FREE: begin
				if (int'(r.id_in) < span) begin
					used_ids[r.id_in] = 1'b0;
					res.status = STAT_OK;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		if (roll < 92)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic bia_req_t mk_req(bia_op_t op, int id, logic [VALUE_BITS-1:0] val);
		bia_req_t r;
		r.func = op;
		r.id_in = ID_BITS'(id);
		r.value_in = val;
		return r;
	endfunction

	function automatic bia_req_t rand_request(int alloc_pct, int free_pct, int span);
		bia_req_t r;
		int roll;
		int id;
		roll = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
		if (roll < 3)
			r = mk_req(OP_BAD, id, $urandom);
		else if (roll < 3 + alloc_pct)
			r = mk_req(OP_ALLOC, id, $urandom);
		else if (roll < 3 + alloc_pct + free_pct)
			r = mk_req(OP_FREE, id, $urandom);
		else
			r = mk_req(OP_LOOKUP, id, $urandom);
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid)
				rsp_due.push_back(table_predict(req));
			if (send_gap != 0) begin
				req_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (req_backlog.size() != 0) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					send_gap <= pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response monitor and backpressure
	always @(posedge clk or negedge arst_n) begin
		bia_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected response id=%0d value=%h status=%0d",
							rsp.id_out, rsp.value_out, rsp.status);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.id_out !== want.id_out || rsp.value_out !== want.value_out ||
					    rsp.status !== want.status) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: exp id=%0d value=%h status=%0d, got id=%0d value=%h status=%0d",
								want.id_out, want.value_out, want.status,
								rsp.id_out, rsp.value_out, rsp.status);
					end
				end
			end
			if (hold_cnt != 0) begin
				rsp_ready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				hold_cnt <= pick_gap();
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[bitmap_id_allocator_table] ERROR");
				$finish;
			end
		end
	end

	// wait until no request is queued, in flight or owed a response
	task automatic drain();
		while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_words(logic [CFG_BITS-1:0] words);
		drain();
		cfg_data <= words;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		words_cfg = words;
	endtask

	initial begin
		int ph_words [8] = '{1, 7, 0, 2, 5, 3, 6, 4};
		int ph_items [8] = '{200, 300, 150, 250, 300, 250, 150, 400};
		int ph_alloc [8] = '{80, 75, 50, 40, 85, 30, 60, 45};
		int ph_free  [8] = '{10, 10, 30, 30, 5, 40, 20, 30};
		used_ids = '0;
		search_from = '0;
		words_cfg = CFG_BITS'(ID_WORDS_DEF);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, bad op, next-fit, free then lookup
		no_idle = 1'b1;
		req_backlog.push_back(mk_req(OP_LOOKUP, 0, 32'h0));
		req_backlog.push_back(mk_req(OP_FREE, 255, 32'h0));
		req_backlog.push_back(mk_req(OP_BAD, 8'hAB, 32'hFFFF_FFFF));
		req_backlog.push_back(mk_req(OP_ALLOC, 255, 32'h0));
		req_backlog.push_back(mk_req(OP_ALLOC, 0, 32'hFFFF_FFFF));
		req_backlog.push_back(mk_req(OP_LOOKUP, 0, 32'h0));
		req_backlog.push_back(mk_req(OP_LOOKUP, 1, 32'h0));
		req_backlog.push_back(mk_req(OP_FREE, 0, 32'h0));
		req_backlog.push_back(mk_req(OP_LOOKUP, 0, 32'h0));
		req_backlog.push_back(mk_req(OP_ALLOC, 0, 32'h5A5A_A5A5));
		req_backlog.push_back(mk_req(OP_LOOKUP, 2, 32'h0));
		req_backlog.push_back(mk_req(OP_LOOKUP, 255, 32'h0));
		req_backlog.push_back(mk_req(OP_FREE, 1, 32'h0));
		req_backlog.push_back(mk_req(OP_ALLOC, 0, 32'h1234_5678));
		write_words(3'd1);
		// ids 64 and up are now out of range
		req_backlog.push_back(mk_req(OP_LOOKUP, 64, 32'h0));
		req_backlog.push_back(mk_req(OP_FREE, 200, 32'h0));
		req_backlog.push_back(mk_req(OP_ALLOC, 0, 32'hDEAD_BEEF));
		req_backlog.push_back(mk_req(OP_LOOKUP, 4, 32'h0));

		// random phases; allocate-heavy ones run the table full
		for (int p = 0; p < 8; p++) begin
			write_words(CFG_BITS'(ph_words[p]));
			no_idle = (p == 6);
			for (int i = 0; i < ph_items[p]; i++)
				req_backlog.push_back(rand_request(ph_alloc[p], ph_free[p], id_span(words_cfg)));
		end

		drain();
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("[bitmap_id_allocator_table] OK");
		else
			$display("[bitmap_id_allocator_table] ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/bia_pkg.sv
rtl/core/bia_ram.sv
rtl/core/bia_queue.sv
rtl/core/bia_front.sv
rtl/core/bia_back.sv
rtl/core/bitmap_id_allocator_table.sv
rtl/core/bia_checker.sv
bench/tb_bitmap_id_allocator_table.sv
